[rtl/dahdsr_envelope_generator_macros.svh]
// Assertion macros used by the checker file.
`ifndef DAHDSR_ENVELOPE_GENERATOR_MACROS_SVH
`define DAHDSR_ENVELOPE_GENERATOR_MACROS_SVH

// Asserts that an antecedent implies a consequence in the same cycle.
`define DEG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that an antecedent implies a consequence in the next cycle.
`define DEG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/deg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package deg_pkg;

    localparam int LenW     = 24;
    localparam int LevW     = 16;
    localparam int FracW    = 15;
    localparam int TabSize  = 256;
    localparam int TabW     = 9;
    localparam int CntW     = 25;
    localparam logic [LevW-1:0] One = 16'h8000;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DELAY   = 3'd1,
        PH_ATTACK  = 3'd2,
        PH_HOLD    = 3'd3,
        PH_DECAY   = 3'd4,
        PH_SUSTAIN = 3'd5,
        PH_RELEASE = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        REG_DELAY   = 3'd0,
        REG_ATTACK  = 3'd1,
        REG_HOLD    = 3'd2,
        REG_DECAY   = 3'd3,
        REG_RELEASE = 3'd4,
        REG_SUSTAIN = 3'd5,
        REG_KEYTRK  = 3'd6,
        REG_EXP     = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG_SCALE,
        ST_TRIG_MUL,
        ST_TICK_SETUP,
        ST_DIV,
        ST_IDX_DIV,
        ST_EXP_MUL,
        ST_FINISH,
        ST_OUT
    } eng_state_t;

    // Queue entry between the front and the back.
    typedef struct packed {
        op_t            op;
        logic [LevW-1:0] key;
    } cmd_t;

    // Table of round(One * exp(-5 i / 256)), built with Q30 integer steps.
    function automatic logic [LevW-1:0] exp_tab(input logic [TabW-1:0] idx);
        logic [63:0] y;
        logic [63:0] term;
        logic signed [63:0] sum;
        logic [63:0] r;
        logic [63:0] p;
        int k;
        int i;
        y = (64'd5 << 30) / 64'(TabSize);
        term = 64'd1 << 30;
        sum = 64'sd1 <<< 30;
        for (k = 1; k <= 14; k++)
        begin
            term = ((term * y) >> 30) / 64'(k);
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        r = (sum < 0) ? 64'd0 : 64'(sum);
        p = 64'd1 << 30;
        if (idx == '0)
            return One;
        for (i = 1; i <= TabSize; i++)
        begin
            p = (p * r) >> 30;
            if (i == int'(idx))
                return LevW'((p + (64'd1 << (29 - FracW))) >> (30 - FracW));
        end
        return '0;
    endfunction

endpackage
`default_nettype wire

[rtl/dahdsr_envelope_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tdata: opcode[1:0], key_pos[17:2]
// m_axis    out        m_axis_tvalid/tready      tdata: level[15:0], phase_code[18:16]
// cfg       in         cfg_valid/cfg_ready       cfg_index[2:0], cfg_data[23:0]
// A tick runs setup, an optional sloped-segment quotient on the shared
// bit-serial divider (with a table multiply in exponential mode), finish and
// output; a trigger runs the five length multiplies; a release only sets state.
// A two-word queue decouples input acceptance from the engine, and the result
// register holds a word while the output stalls. Reset clears control state.
module dahdsr_envelope_generator
    import deg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // opcode, key_pos
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // level, phase_code
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);

    logic [LenW-1:0] len_reg [5];
    logic [LevW-1:0] sus_reg;
    logic [LevW-1:0] trk_mag_reg;
    logic            trk_neg_reg;
    logic            exp_reg;
    logic [16:0]     kt;
    logic [16:0]     kt_abs;
    logic            q_valid, q_ready;
    cmd_t            q_cmd;
    logic [LevW-1:0] level;
    logic [2:0]      phase_code;

    assign cfg_ready = 1'b1;
    assign kt = cfg_data[16:0];
    assign kt_abs = kt[16] ? (17'd0 - kt) : kt;
    assign m_axis_tdata = {5'd0, phase_code, level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '{default: '0};
            sus_reg <= '0;
            trk_mag_reg <= '0;
            trk_neg_reg <= 1'b0;
            exp_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DELAY:   len_reg[0] <= cfg_data;
                REG_ATTACK:  len_reg[1] <= cfg_data;
                REG_HOLD:    len_reg[2] <= cfg_data;
                REG_DECAY:   len_reg[3] <= cfg_data;
                REG_RELEASE: len_reg[4] <= cfg_data;
                REG_SUSTAIN: sus_reg <= (cfg_data[15:0] > One) ? One : cfg_data[15:0];
                REG_KEYTRK:
                begin
                    trk_neg_reg <= kt[16];
                    trk_mag_reg <= (kt_abs > 17'(One)) ? One : kt_abs[15:0];
                end
                REG_EXP:     exp_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    deg_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[1:0]), .in_key(s_axis_tdata[17:2]),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    deg_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .base_len(len_reg), .sus_cfg(sus_reg), .trk_mag(trk_mag_reg),
        .trk_neg(trk_neg_reg), .exp_mode(exp_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_level(level), .out_phase(phase_code)
    );

endmodule
`default_nettype wire

[rtl/deg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module deg_front
    import deg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [LevW-1:0]  in_key,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output cmd_t                  q_cmd
);

    // Two-entry queue; opcode three is dropped here.
    cmd_t        mem_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready && (op_t'(in_op) != OP_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= '{op: op_t'(in_op), key: in_key};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/deg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module deg_back
    import deg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire cmd_t             q_cmd,
    input  wire logic [LenW-1:0]  base_len [5],
    input  wire logic [LevW-1:0]  sus_cfg,
    input  wire logic [LevW-1:0]  trk_mag,
    input  wire logic             trk_neg,
    input  wire logic             exp_mode,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [LevW-1:0]       out_level,
    output logic [2:0]            out_phase
);

    eng_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [LevW-1:0] lev_reg, lev_next;
    logic [LevW-1:0] astart_reg, astart_next;
    logic [LevW-1:0] rstart_reg, rstart_next;
    logic [LevW-1:0] sus_reg, sus_next;
    logic [LenW-1:0] slen_reg [5];
    logic [LenW-1:0] slen_next [5];
    logic [LevW-1:0] key_reg, key_next;
    logic [LevW-1:0] scale_reg, scale_next;
    logic [2:0]      seg_reg, seg_next;
    // Shared restoring divider: num / den.
    logic [47:0]     num_reg, num_next;
    logic [LenW-1:0] den_reg, den_next;
    logic [LenW:0]   rem_reg, rem_next;
    logic [5:0]      bit_reg, bit_next;
    logic [LevW-1:0] span_reg, span_next;
    logic [LevW-1:0] qout_reg, qout_next;
    logic [LevW-1:0] olev_reg, olev_next;
    logic [2:0]      oph_reg, oph_next;
    logic            ov_reg, ov_next;

    logic [LenW-1:0] len;
    logic [LevW-1:0] keyc;
    logic [31:0]     prod;
    logic [LenW:0]   trial;
    logic [CntW-1:0] cnt_inc;
    logic            seg_end;
    logic [TabW-1:0] tidx;
    logic [31:0]     emul;
    logic [LevW-1:0] tv;
    logic [LenW+LevW-1:0] lmul;

    assign len = slen_reg[phase_reg == PH_DELAY   ? 3'd0 :
                          phase_reg == PH_ATTACK  ? 3'd1 :
                          phase_reg == PH_HOLD    ? 3'd2 :
                          phase_reg == PH_DECAY   ? 3'd3 : 3'd4];
    assign keyc = (q_cmd.key > One) ? One : q_cmd.key;
    assign cnt_inc = cnt_reg + 1'b1;
    assign seg_end = cnt_inc > {1'b0, len};
    assign trial = {rem_reg[LenW-1:0], num_reg[47]} - {1'b0, den_reg};
    assign tidx = (qout_reg > LevW'(TabSize)) ? TabW'(TabSize) : qout_reg[TabW-1:0];
    assign tv = exp_tab(tidx);
    assign emul = {16'd0, tv} * {16'd0, span_reg};
    assign prod = {16'd0, key_reg} * {16'd0, scale_reg};
    assign lmul = LenW'(base_len[seg_reg]) * scale_reg;
    assign q_ready = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_level = olev_reg;
    assign out_phase = oph_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    if (q_cmd.op == OP_TRIGGER)
                        state_next = ST_TRIG_SCALE;
                    else if (q_cmd.op == OP_TICK)
                        state_next = ST_TICK_SETUP;
                end
            end
            ST_TRIG_SCALE: state_next = ST_TRIG_MUL;
            ST_TRIG_MUL:   state_next = (seg_reg == 3'd4) ? ST_IDLE : ST_TRIG_MUL;
            ST_TICK_SETUP:
            begin
                if (phase_reg inside {PH_ATTACK, PH_DECAY, PH_RELEASE} && len != '0
                    && !(phase_reg == PH_RELEASE && cnt_reg == '0))
                    state_next = exp_mode ? ST_IDX_DIV : ST_DIV;
                else
                    state_next = ST_FINISH;
            end
            ST_DIV:     state_next = (bit_reg == 6'd0) ? ST_FINISH : ST_DIV;
            ST_IDX_DIV: state_next = (bit_reg == 6'd0) ? ST_EXP_MUL : ST_IDX_DIV;
            ST_EXP_MUL: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_OUT;
            ST_OUT:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        lev_next = lev_reg;
        astart_next = astart_reg;
        rstart_next = rstart_reg;
        sus_next = sus_reg;
        slen_next = slen_reg;
        key_next = key_reg;
        scale_next = scale_reg;
        seg_next = seg_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        span_next = span_reg;
        qout_next = qout_reg;
        olev_next = olev_reg;
        oph_next = oph_reg;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready)
                begin
                    if (q_cmd.op == OP_TRIGGER)
                    begin
                        key_next = trk_neg ? keyc : One - keyc;
                        scale_next = trk_mag;
                        phase_next = PH_DELAY;
                        cnt_next = '0;
                        astart_next = lev_reg;
                        sus_next = sus_cfg;
                    end
                    else if (q_cmd.op == OP_RELEASE)
                    begin
                        phase_next = PH_RELEASE;
                        cnt_next = '0;
                    end
                end
            end
            ST_TRIG_SCALE:
            begin
                scale_next = One - LevW'(prod >> FracW);
                seg_next = 3'd0;
            end
            ST_TRIG_MUL:
            begin
                slen_next[seg_reg] = LenW'(lmul >> FracW);
                seg_next = seg_reg + 3'd1;
            end
            ST_TICK_SETUP:
            begin
                rem_next = '0;
                bit_next = 6'd47;
                den_next = len;
                if (exp_mode)
                    num_next = 48'(cnt_reg) << 8;
                else
                begin
                    case (phase_reg)
                        PH_ATTACK: span_next = One - astart_reg;
                        PH_DECAY:  span_next = One - sus_reg;
                        default:   span_next = rstart_reg;
                    endcase
                    num_next = 48'({LevW'(0), cnt_reg}) * 48'(span_next);
                end
                if (exp_mode)
                begin
                    case (phase_reg)
                        PH_ATTACK: span_next = One - astart_reg;
                        PH_DECAY:  span_next = One - sus_reg;
                        default:   span_next = rstart_reg;
                    endcase
                end
            end
            ST_DIV, ST_IDX_DIV:
            begin
                if (!trial[LenW])
                    rem_next = trial;
                else
                    rem_next = {rem_reg[LenW-1:0], num_reg[47]};
                num_next = {num_reg[46:0], !trial[LenW]};
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd0)
                begin
                    // Quotient saturates; only narrow quotients matter here.
                    qout_next = (num_next[47:LevW] != '0) ? '1 : num_next[LevW-1:0];
                end
            end
            ST_EXP_MUL:
            begin
                qout_next = LevW'(emul >> FracW);
            end
            ST_FINISH:
            begin
                case (phase_reg)
                    PH_DELAY:
                    begin
                        if (len != '0)
                            lev_next = '0;
                    end
                    PH_ATTACK:
                    begin
                        if (len == '0)
                            lev_next = One;
                        else if (!exp_mode)
                            lev_next = astart_reg + qout_reg;
                        else
                            lev_next = One - qout_reg;
                    end
                    PH_HOLD: lev_next = One;
                    PH_DECAY:
                    begin
                        if (len == '0)
                            lev_next = sus_reg;
                        else if (!exp_mode)
                            lev_next = One - qout_reg;
                        else
                            lev_next = sus_reg + qout_reg;
                        if (seg_end)
                            lev_next = sus_reg;
                    end
                    PH_SUSTAIN: ;
                    PH_RELEASE:
                    begin
                        if (len == '0)
                            lev_next = '0;
                        else if (cnt_reg == '0)
                            rstart_next = lev_reg;
                        else if (!exp_mode)
                            lev_next = rstart_reg - qout_reg;
                        else
                            lev_next = qout_reg;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        lev_next = '0;
                    end
                endcase
                if (phase_reg inside {PH_DELAY, PH_ATTACK, PH_HOLD, PH_DECAY, PH_RELEASE})
                begin
                    cnt_next = cnt_inc;
                    if (seg_end)
                    begin
                        cnt_next = '0;
                        case (phase_reg)
                            PH_DELAY:  phase_next = PH_ATTACK;
                            PH_ATTACK: phase_next = PH_HOLD;
                            PH_HOLD:   phase_next = PH_DECAY;
                            PH_DECAY:  phase_next = PH_SUSTAIN;
                            default:   phase_next = PH_IDLE;
                        endcase
                    end
                end
            end
            ST_OUT:
            begin
                ov_next = 1'b1;
                olev_next = lev_reg;
                oph_next = phase_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        scale_reg <= scale_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        span_reg <= span_next;
        qout_reg <= qout_next;
        olev_reg <= olev_next;
        oph_reg <= oph_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            cnt_reg <= '0;
            lev_reg <= '0;
            astart_reg <= '0;
            rstart_reg <= '0;
            sus_reg <= '0;
            slen_reg <= '{default: '0};
            seg_reg <= '0;
            bit_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            lev_reg <= lev_next;
            astart_reg <= astart_next;
            rstart_reg <= rstart_next;
            sus_reg <= sus_next;
            slen_reg <= slen_next;
            seg_reg <= seg_next;
            bit_reg <= bit_next;
            ov_reg <= ov_next;
        end
    end

endmodule
`default_nettype wire

[rtl/deg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "dahdsr_envelope_generator_macros.svh"
module deg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata
);

    `DEG_ASSERT_IMP(a_in_ready_known, s_axis_tvalid, !$isunknown(s_axis_tready))
    `DEG_ASSERT_IMP(a_level_range, m_axis_tvalid, m_axis_tdata[15:0] <= 16'h8000)
    `DEG_ASSERT_IMP(a_phase_range, m_axis_tvalid, m_axis_tdata[18:16] != 3'd7)
    `DEG_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:19] == 5'd0)
    `DEG_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind dahdsr_envelope_generator deg_checker u_deg_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
